>>> src/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared widths, register codes, types and saturation helpers of the rigid
// pose transform.
// ----------------------------------------------------------------------------
package prt_pkg;

   // field formats
   localparam int POS_W      = 32;   // signed Q16.16
   localparam int QUAT_W     = 16;   // signed, QUAT_W-2 fraction bits
   localparam int ROT_W      = 16;   // rotation words, signed Q1.14
   localparam int ROT_FRAC   = 14;
   localparam int SCALE_W    = 16;   // signed Q8.8
   localparam int SCALE_FRAC = 8;
   localparam int CONF_W     = 16;   // unsigned Q1.15
   localparam int CONF_FRAC  = 15;
   localparam int BTN_W      = 16;

   // configuration port
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int SCALE_PACK_W = 3 * SCALE_W;
   localparam int ROT_PACK_W   = 4 * ROT_W;

   // derived datapath widths
   localparam int QPROD_W   = 2 * ROT_W;             // rotation word squared
   localparam int MAT_SUM_W = QPROD_W + 2;           // unrounded matrix entry
   localparam int MAT_W     = MAT_SUM_W - ROT_FRAC;  // rounded matrix entry
   localparam int ROWP_W    = MAT_W + POS_W;         // matrix times position
   localparam int ROWS_W    = ROWP_W + 2;            // row sum
   localparam int HPROD_W   = ROT_W + QUAT_W;        // quaternion term
   localparam int HSUM_W    = HPROD_W + 2;           // quaternion component sum
   localparam int QSAT_W    = HSUM_W - ROT_FRAC;     // rounded component
   localparam int SPROD_W   = POS_W + SCALE_W;       // scaled position
   localparam int SSUM_W    = SPROD_W - SCALE_FRAC + 1;
   localparam int SAT_W     = SSUM_W;                // widest value that is clamped
   localparam int CPROD_W   = 2 * CONF_W;
   localparam int CSUM_W    = CPROD_W + 1;
   localparam int CRND_W    = CSUM_W - CONF_FRAC;

   localparam int NUM_STAGES = 6;

   localparam logic [CONF_W-1:0]       CONF_MAX    = CONF_W'(32768);
   localparam logic [SCALE_PACK_W-1:0] SCALE_RESET = 48'h0100_0100_0100;
   localparam logic [ROT_PACK_W-1:0]   ROT_RESET   = 64'h4000_0000_0000_0000;
   localparam logic [CONF_W-1:0]       GAIN_RESET  = CONF_MAX;

   // bits of the mode register
   localparam int MODE_POS = 0;
   localparam int MODE_ORI = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRANS_X = 3'd0,
      CSR_TRANS_Y = 3'd1,
      CSR_TRANS_Z = 3'd2,
      CSR_SCALE   = 3'd3,
      CSR_ROT     = 3'd4,
      CSR_MODE    = 3'd5,
      CSR_GAIN    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0]   trans;
      logic [2:0][SCALE_W-1:0] scale;
      logic [3:0][ROT_W-1:0]   rot;    // x,y,z,w from index 0 up
      logic                    pos_mode;
      logic                    ori_mode;
      logic [CONF_W-1:0]       gain;
   } cfg_type;

   // rotation matrix, [row][column]
   typedef logic [2:0][2:0][MAT_W-1:0] mat_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_load_type;

   // clamp to the position range, flag in the top bit
   function automatic logic [POS_W:0] sat_pos(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-POS_W:0] hi_bits;
      logic [POS_W-1:0]     r;
      logic                 f;
      hi_bits = v[SAT_W-1:POS_W-1];
      f = !((&hi_bits) || !(|hi_bits));
      if (!f) begin
         r = v[POS_W-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(POS_W-1){1'b1}}};
      end
      return {f, r};
   endfunction

   // clamp to the quaternion range, flag in the top bit
   function automatic logic [QUAT_W:0] sat_quat(input logic signed [QSAT_W-1:0] v);
      logic [QSAT_W-QUAT_W:0] hi_bits;
      logic [QUAT_W-1:0]      r;
      logic                   f;
      hi_bits = v[QSAT_W-1:QUAT_W-1];
      f = !((&hi_bits) || !(|hi_bits));
      if (!f) begin
         r = v[QUAT_W-1:0];
      end else if (v[QSAT_W-1]) begin
         r = {1'b1, {(QUAT_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(QUAT_W-1){1'b1}}};
      end
      return {f, r};
   endfunction

endpackage

>>> src/pose_rigid_transform.sv
// ----------------------------------------------------------------------------
// pose_rigid_transform
// Fixed-point rigid transform of tracked pose samples: rotation, scale and
// translation of the position, quaternion rotation of the orientation.
// ----------------------------------------------------------------------------
// One sample is taken per clock and one result leaves per clock while the
// result side does not stall; each sample passes every stage register before
// its result is offered. The six register stages follow the multipliers:
// capture, quaternion and confidence products, matrix-by-position products,
// row sums with clamp, per-axis scale product, and rounding with translation
// and clamp. A stall on the result side backs up through the stages and holds
// off the input only when no stage has a free slot. Registers must be written
// only while no sample is in flight; the block does not enforce it. The rotation
// matrix follows a write through the product register, ahead of later samples.
module pose_rigid_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   // input samples
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [prt_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [prt_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [prt_pkg::POS_W-1:0]      req_pos_z,
   input  logic signed [prt_pkg::QUAT_W-1:0]     req_quat_x,
   input  logic signed [prt_pkg::QUAT_W-1:0]     req_quat_y,
   input  logic signed [prt_pkg::QUAT_W-1:0]     req_quat_z,
   input  logic signed [prt_pkg::QUAT_W-1:0]     req_quat_w,
   input  logic [prt_pkg::CONF_W-1:0]            req_confidence,
   input  logic [prt_pkg::BTN_W-1:0]             req_buttons,
   // results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [prt_pkg::POS_W-1:0]      rsp_pos_x,
   output logic signed [prt_pkg::POS_W-1:0]      rsp_pos_y,
   output logic signed [prt_pkg::POS_W-1:0]      rsp_pos_z,
   output logic signed [prt_pkg::QUAT_W-1:0]     rsp_quat_x,
   output logic signed [prt_pkg::QUAT_W-1:0]     rsp_quat_y,
   output logic signed [prt_pkg::QUAT_W-1:0]     rsp_quat_z,
   output logic signed [prt_pkg::QUAT_W-1:0]     rsp_quat_w,
   output logic [prt_pkg::CONF_W-1:0]            rsp_confidence,
   output logic [prt_pkg::BTN_W-1:0]             rsp_buttons,
   output logic                                  rsp_saturated,
   // register writes
   input  logic                                  csr_wr_en,
   input  logic [prt_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import prt_pkg::*;

   cfg_type                cfg;
   mat_type                mat;
   stage_load_type         ld;
   logic [2:0][POS_W-1:0]  pos_in, pos_out;
   logic [3:0][QUAT_W-1:0] quat_in, quat_out;
   logic                   pos_sat, ori_sat;

   assign pos_in  = {req_pos_z, req_pos_y, req_pos_x};
   assign quat_in = {req_quat_w, req_quat_z, req_quat_y, req_quat_x};

   prt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .mat       (mat)
   );

   prt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ld        (ld)
   );

   prt_position u_position (
      .clock   (clock),
      .ld      (ld),
      .cfg     (cfg),
      .mat     (mat),
      .req_pos (pos_in),
      .rsp_pos (pos_out),
      .rsp_sat (pos_sat)
   );

   prt_orient u_orient (
      .clock          (clock),
      .ld             (ld),
      .cfg            (cfg),
      .req_quat       (quat_in),
      .req_confidence (req_confidence),
      .req_buttons    (req_buttons),
      .rsp_quat       (quat_out),
      .rsp_confidence (rsp_confidence),
      .rsp_buttons    (rsp_buttons),
      .rsp_sat        (ori_sat)
   );

   assign rsp_pos_x     = pos_out[0];
   assign rsp_pos_y     = pos_out[1];
   assign rsp_pos_z     = pos_out[2];
   assign rsp_quat_x    = quat_out[0];
   assign rsp_quat_y    = quat_out[1];
   assign rsp_quat_z    = quat_out[2];
   assign rsp_quat_w    = quat_out[3];
   assign rsp_saturated = pos_sat | ori_sat;

endmodule

>>> src/prt_csr.sv
// ----------------------------------------------------------------------------
// prt_csr
// Configuration registers and the rotation matrix derived from the
// configured quaternion (products, then rounded entries).
// ----------------------------------------------------------------------------
module prt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [prt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output prt_pkg::cfg_type                  cfg,
   output prt_pkg::mat_type                  mat
);
   import prt_pkg::*;

   typedef struct packed {
      logic signed [QPROD_W-1:0] xx;
      logic signed [QPROD_W-1:0] yy;
      logic signed [QPROD_W-1:0] zz;
      logic signed [QPROD_W-1:0] ww;
      logic signed [QPROD_W-1:0] xy;
      logic signed [QPROD_W-1:0] xz;
      logic signed [QPROD_W-1:0] yz;
      logic signed [QPROD_W-1:0] wx;
      logic signed [QPROD_W-1:0] wy;
      logic signed [QPROD_W-1:0] wz;
   } qprod_type;

   cfg_type   cfg_ff, cfg_in;
   qprod_type prod_ff, prod_in;
   mat_type   mat_ff, mat_in;

   function automatic logic signed [MAT_SUM_W-1:0] ext(input logic signed [QPROD_W-1:0] v);
      return MAT_SUM_W'(v);
   endfunction

   function automatic logic [MAT_W-1:0] rnd_mat(input logic signed [MAT_SUM_W-1:0] n);
      logic signed [MAT_SUM_W-1:0] a;
      a = n + (MAT_SUM_W'(1) << (ROT_FRAC-1));
      return a[MAT_SUM_W-1:ROT_FRAC];
   endfunction

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRANS_X: cfg_in.trans[0] = csr_wdata[POS_W-1:0];
            CSR_TRANS_Y: cfg_in.trans[1] = csr_wdata[POS_W-1:0];
            CSR_TRANS_Z: cfg_in.trans[2] = csr_wdata[POS_W-1:0];
            CSR_SCALE:   cfg_in.scale    = csr_wdata[SCALE_PACK_W-1:0];
            CSR_ROT:     cfg_in.rot      = csr_wdata[ROT_PACK_W-1:0];
            CSR_MODE: begin
               cfg_in.pos_mode = csr_wdata[MODE_POS];
               cfg_in.ori_mode = csr_wdata[MODE_ORI];
            end
            CSR_GAIN:    cfg_in.gain     = csr_wdata[CONF_W-1:0];
            default:     cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trans    <= '0;
         cfg_ff.scale    <= SCALE_RESET;
         cfg_ff.rot      <= ROT_RESET;
         cfg_ff.pos_mode <= 1'b0;
         cfg_ff.ori_mode <= 1'b0;
         cfg_ff.gain     <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // quaternion products, refreshed every cycle
   always_comb begin
      logic signed [ROT_W-1:0] x, y, z, w;
      x = cfg_ff.rot[0];
      y = cfg_ff.rot[1];
      z = cfg_ff.rot[2];
      w = cfg_ff.rot[3];
      prod_in.xx = x * x;
      prod_in.yy = y * y;
      prod_in.zz = z * z;
      prod_in.ww = w * w;
      prod_in.xy = x * y;
      prod_in.xz = x * z;
      prod_in.yz = y * z;
      prod_in.wx = w * x;
      prod_in.wy = w * y;
      prod_in.wz = w * z;
   end

   always_comb begin
      mat_in[0][0] = rnd_mat(ext(prod_ff.ww) + ext(prod_ff.xx) - ext(prod_ff.yy)
                             - ext(prod_ff.zz));
      mat_in[0][1] = rnd_mat((ext(prod_ff.xy) - ext(prod_ff.wz)) <<< 1);
      mat_in[0][2] = rnd_mat((ext(prod_ff.xz) + ext(prod_ff.wy)) <<< 1);
      mat_in[1][0] = rnd_mat((ext(prod_ff.xy) + ext(prod_ff.wz)) <<< 1);
      mat_in[1][1] = rnd_mat(ext(prod_ff.ww) - ext(prod_ff.xx) + ext(prod_ff.yy)
                             - ext(prod_ff.zz));
      mat_in[1][2] = rnd_mat((ext(prod_ff.yz) - ext(prod_ff.wx)) <<< 1);
      mat_in[2][0] = rnd_mat((ext(prod_ff.xz) - ext(prod_ff.wy)) <<< 1);
      mat_in[2][1] = rnd_mat((ext(prod_ff.yz) + ext(prod_ff.wx)) <<< 1);
      mat_in[2][2] = rnd_mat(ext(prod_ff.ww) - ext(prod_ff.xx) - ext(prod_ff.yy)
                             + ext(prod_ff.zz));
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      mat_ff  <= mat_in;
   end

   assign cfg = cfg_ff;
   assign mat = mat_ff;

endmodule

>>> src/prt_ctrl.sv
// ----------------------------------------------------------------------------
// prt_ctrl
// Valid bits and stall chain of the six-stage pipeline.
// ----------------------------------------------------------------------------
module prt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output prt_pkg::stage_load_type  ld
);
   import prt_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, ready;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES-2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ld.s1     = ready[0];
   assign ld.s2     = ready[1];
   assign ld.s3     = ready[2];
   assign ld.s4     = ready[3];
   assign ld.s5     = ready[4];
   assign ld.s6     = ready[5];
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted transfer did not enter the first stage");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && rsp_stall) |-> req_stall)
      else $error("full stalled pipeline took a transfer");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && !req_stall) && rsp_valid && !rsp_stall)
      |=> $countones(valid_ff) == $past($countones(valid_ff)) - 1)
      else $error("item count wrong after output transfer");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      ((req_valid && !req_stall) && !(rsp_valid && !rsp_stall))
      |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("item count wrong after input transfer");

endmodule

>>> src/prt_position.sv
// ----------------------------------------------------------------------------
// prt_position
// Position path: matrix products, row sums with clamp, per-axis scale,
// rounding, translation and final clamp.
// ----------------------------------------------------------------------------
module prt_position (
   input  logic                                 clock,
   input  prt_pkg::stage_load_type              ld,
   input  prt_pkg::cfg_type                     cfg,
   input  prt_pkg::mat_type                     mat,
   input  logic [2:0][prt_pkg::POS_W-1:0]       req_pos,
   output logic [2:0][prt_pkg::POS_W-1:0]       rsp_pos,
   output logic                                 rsp_sat
);
   import prt_pkg::*;

   logic [2:0][POS_W-1:0]     p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [ROWP_W-1:0]  rp_ff [3][3];
   logic signed [ROWP_W-1:0]  rp_in [3][3];
   logic [2:0][POS_W-1:0]     rv4_ff, rv4_in;
   logic                      sat4_ff, sat4_in, sat5_ff;
   logic signed [SPROD_W-1:0] sp5_ff [3];
   logic signed [SPROD_W-1:0] sp5_in [3];
   logic [2:0][POS_W-1:0]     pos6_ff, pos6_in;
   logic                      sat6_ff, sat6_in;

   // stage 3: matrix times position, term by term
   always_comb begin
      logic signed [MAT_W-1:0] mv;
      logic signed [POS_W-1:0] pv;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mv = mat[i][j];
            pv = p2_ff[j];
            rp_in[i][j] = mv * pv;
         end
      end
   end

   // stage 4: row sums, round by the rotation fraction, clamp
   always_comb begin
      logic signed [ROWS_W-1:0]          acc;
      logic signed [ROWS_W-ROT_FRAC-1:0] rr;
      logic [POS_W:0]                    s;
      sat4_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = ROWS_W'(rp_ff[i][0]) + ROWS_W'(rp_ff[i][1]) + ROWS_W'(rp_ff[i][2])
               + (ROWS_W'(1) << (ROT_FRAC-1));
         rr = acc[ROWS_W-1:ROT_FRAC];
         s  = sat_pos(SAT_W'(rr));
         rv4_in[i] = s[POS_W-1:0];
         sat4_in   = sat4_in | (s[POS_W] & cfg.pos_mode);
      end
   end

   // stage 5: scale the rotated or the raw position
   always_comb begin
      logic signed [POS_W-1:0]   op;
      logic signed [SCALE_W-1:0] sc;
      for (int i = 0; i < 3; i++) begin
         op = cfg.pos_mode ? rv4_ff[i] : p4_ff[i];
         sc = cfg.scale[i];
         sp5_in[i] = op * sc;
      end
   end

   // stage 6: round by the scale fraction, translate in position mode, clamp
   always_comb begin
      logic signed [SPROD_W-1:0]            a;
      logic signed [SPROD_W-SCALE_FRAC-1:0] sh;
      logic signed [POS_W-1:0]              t;
      logic signed [SSUM_W-1:0]             sum;
      logic [POS_W:0]                       s;
      sat6_in = sat5_ff;
      for (int i = 0; i < 3; i++) begin
         a   = sp5_ff[i] + (SPROD_W'(1) << (SCALE_FRAC-1));
         sh  = a[SPROD_W-1:SCALE_FRAC];
         t   = cfg.pos_mode ? cfg.trans[i] : '0;
         sum = SSUM_W'(sh) + SSUM_W'(t);
         s   = sat_pos(sum);
         pos6_in[i] = s[POS_W-1:0];
         sat6_in    = sat6_in | s[POS_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ld.s1) begin
         p1_ff <= req_pos;
      end
      if (ld.s2) begin
         p2_ff <= p1_ff;
      end
      if (ld.s3) begin
         rp_ff <= rp_in;
         p3_ff <= p2_ff;
      end
      if (ld.s4) begin
         rv4_ff  <= rv4_in;
         sat4_ff <= sat4_in;
         p4_ff   <= p3_ff;
      end
      if (ld.s5) begin
         sp5_ff  <= sp5_in;
         sat5_ff <= sat4_ff;
      end
      if (ld.s6) begin
         pos6_ff <= pos6_in;
         sat6_ff <= sat6_in;
      end
   end

   assign rsp_pos = pos6_ff;
   assign rsp_sat = sat6_ff;

endmodule

>>> src/prt_orient.sv
// ----------------------------------------------------------------------------
// prt_orient
// Orientation and confidence path: Hamilton product with the configured
// rotation, confidence gain, and the button bits carried alongside.
// ----------------------------------------------------------------------------
module prt_orient (
   input  logic                                 clock,
   input  prt_pkg::stage_load_type              ld,
   input  prt_pkg::cfg_type                     cfg,
   input  logic [3:0][prt_pkg::QUAT_W-1:0]      req_quat,
   input  logic [prt_pkg::CONF_W-1:0]           req_confidence,
   input  logic [prt_pkg::BTN_W-1:0]            req_buttons,
   output logic [3:0][prt_pkg::QUAT_W-1:0]      rsp_quat,
   output logic [prt_pkg::CONF_W-1:0]           rsp_confidence,
   output logic [prt_pkg::BTN_W-1:0]            rsp_buttons,
   output logic                                 rsp_sat
);
   import prt_pkg::*;

   typedef struct packed {
      logic [3:0][QUAT_W-1:0] q;
      logic [CONF_W-1:0]      conf;
      logic [BTN_W-1:0]       btn;
      logic                   sat;
   } ori_res_type;

   logic [3:0][QUAT_W-1:0]    q1_ff, q2_ff;
   logic [CONF_W-1:0]         conf1_ff;
   logic [BTN_W-1:0]          btn1_ff, btn2_ff;
   logic signed [HPROD_W-1:0] hp_ff [4][4];
   logic signed [HPROD_W-1:0] hp_in [4][4];
   logic [CPROD_W-1:0]        cp2_ff, cp2_in;
   ori_res_type               res3_ff, res3_in, res4_ff, res5_ff, res6_ff;

   function automatic logic signed [HSUM_W-1:0] hx(input logic signed [HPROD_W-1:0] v);
      return HSUM_W'(v);
   endfunction

   // stage 2: every rotation word times every input component
   always_comb begin
      logic signed [ROT_W-1:0]  rv;
      logic signed [QUAT_W-1:0] qv;
      for (int a = 0; a < 4; a++) begin
         for (int b = 0; b < 4; b++) begin
            rv = cfg.rot[a];
            qv = q1_ff[b];
            hp_in[a][b] = rv * qv;
         end
      end
      cp2_in = conf1_ff * cfg.gain;
   end

   // stage 3: Hamilton sums, rounding, clamps
   always_comb begin
      logic signed [HSUM_W-1:0] h [4];
      logic signed [HSUM_W-1:0] a;
      logic signed [QSAT_W-1:0] rq;
      logic [QUAT_W:0]          s;
      logic [CSUM_W-1:0]        c;
      logic [CRND_W-1:0]        cr;
      // index 0..3 is x,y,z,w on both operands
      h[0] = hx(hp_ff[3][0]) + hx(hp_ff[0][3]) + hx(hp_ff[1][2]) - hx(hp_ff[2][1]);
      h[1] = hx(hp_ff[3][1]) - hx(hp_ff[0][2]) + hx(hp_ff[1][3]) + hx(hp_ff[2][0]);
      h[2] = hx(hp_ff[3][2]) + hx(hp_ff[0][1]) - hx(hp_ff[1][0]) + hx(hp_ff[2][3]);
      h[3] = hx(hp_ff[3][3]) - hx(hp_ff[0][0]) - hx(hp_ff[1][1]) - hx(hp_ff[2][2]);
      res3_in.sat = 1'b0;
      for (int k = 0; k < 4; k++) begin
         a  = h[k] + (HSUM_W'(1) << (ROT_FRAC-1));
         rq = a[HSUM_W-1:ROT_FRAC];
         s  = sat_quat(rq);
         res3_in.q[k] = cfg.ori_mode ? s[QUAT_W-1:0] : q2_ff[k];
         res3_in.sat  = res3_in.sat | (s[QUAT_W] & cfg.ori_mode);
      end
      c  = CSUM_W'(cp2_ff) + (CSUM_W'(1) << (CONF_FRAC-1));
      cr = c[CSUM_W-1:CONF_FRAC];
      if (cr > CRND_W'(CONF_MAX)) begin
         res3_in.conf = CONF_MAX;
         res3_in.sat  = 1'b1;
      end else begin
         res3_in.conf = cr[CONF_W-1:0];
      end
      res3_in.btn = btn2_ff;
   end

   always_ff @(posedge clock) begin
      if (ld.s1) begin
         q1_ff    <= req_quat;
         conf1_ff <= req_confidence;
         btn1_ff  <= req_buttons;
      end
      if (ld.s2) begin
         hp_ff   <= hp_in;
         cp2_ff  <= cp2_in;
         q2_ff   <= q1_ff;
         btn2_ff <= btn1_ff;
      end
      if (ld.s3) begin
         res3_ff <= res3_in;
      end
      if (ld.s4) begin
         res4_ff <= res3_ff;
      end
      if (ld.s5) begin
         res5_ff <= res4_ff;
      end
      if (ld.s6) begin
         res6_ff <= res5_ff;
      end
   end

   assign rsp_quat       = res6_ff.q;
   assign rsp_confidence = res6_ff.conf;
   assign rsp_buttons    = res6_ff.btn;
   assign rsp_sat        = res6_ff.sat;

endmodule

>>> tb/pose_transform_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_transform_checker
// Watches the sample and result channels and the register port of the rigid
// pose transform, predicts each result from its own copy of the registers and
// compares every result field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module pose_transform_checker
   import prt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic signed [POS_W-1:0]  req_pos_x,
   input  logic signed [POS_W-1:0]  req_pos_y,
   input  logic signed [POS_W-1:0]  req_pos_z,
   input  logic signed [QUAT_W-1:0] req_quat_x,
   input  logic signed [QUAT_W-1:0] req_quat_y,
   input  logic signed [QUAT_W-1:0] req_quat_z,
   input  logic signed [QUAT_W-1:0] req_quat_w,
   input  logic [CONF_W-1:0]        req_confidence,
   input  logic [BTN_W-1:0]         req_buttons,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [POS_W-1:0]  rsp_pos_x,
   input  logic signed [POS_W-1:0]  rsp_pos_y,
   input  logic signed [POS_W-1:0]  rsp_pos_z,
   input  logic signed [QUAT_W-1:0] rsp_quat_x,
   input  logic signed [QUAT_W-1:0] rsp_quat_y,
   input  logic signed [QUAT_W-1:0] rsp_quat_z,
   input  logic signed [QUAT_W-1:0] rsp_quat_w,
   input  logic [CONF_W-1:0]        rsp_confidence,
   input  logic [BTN_W-1:0]         rsp_buttons,
   input  logic                     rsp_saturated,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output int                       fail_count,
   output int                       pending
);

   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic [2:0][POS_W-1:0]  pos;
      logic [3:0][QUAT_W-1:0] quat;
      logic [CONF_W-1:0]      confidence;
      logic [BTN_W-1:0]       buttons;
      logic                   saturated;
   } pose_result_t;

   // register copy
   logic [2:0][POS_W-1:0]   trans_reg;
   logic [SCALE_PACK_W-1:0] scale_reg;
   logic [ROT_PACK_W-1:0]   rot_reg;
   logic [1:0]              mode_reg;
   logic [CONF_W-1:0]       gain_reg;

   pose_result_t expected_poses[$];
   int           results_seen;

   // round to nearest, ties up
   function automatic longint round_by(longint v, int k);
      return (v + (longint'(1) <<< (k - 1))) >>> k;
   endfunction

   function automatic bit out_of_range(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      return (v > hi) || (v < -hi - 1);
   endfunction

   function automatic longint clamp_to(longint v, int w);
      longint hi;
      hi = (longint'(1) <<< (w - 1)) - 1;
      if (v > hi) begin
         return hi;
      end else if (v < -hi - 1) begin
         return -hi - 1;
      end
      return v;
   endfunction

   function automatic pose_result_t transform_pose(
      input logic [2:0][POS_W-1:0]  pos_in,
      input logic [3:0][QUAT_W-1:0] quat_in,
      input logic [CONF_W-1:0]      conf_in,
      input logic [BTN_W-1:0]       buttons_in
   );
      pose_result_t res;
      longint p[3], sc[3], tr[3], pq[4], rq[4], op[3], oq[4];
      longint nm[3][3], mt[3][3], hm[4];
      longint x, y, z, w, acc, v, conf;
      logic sat;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         p[i]  = $signed(pos_in[i]);
         sc[i] = $signed(scale_reg[SCALE_W*i +: SCALE_W]);
         tr[i] = $signed(trans_reg[i]);
      end
      for (int i = 0; i < 4; i++) begin
         pq[i] = $signed(quat_in[i]);
         rq[i] = $signed(rot_reg[ROT_W*i +: ROT_W]);
      end
      x = rq[0];
      y = rq[1];
      z = rq[2];
      w = rq[3];

      // q v q* as a matrix, no normalization of q
      nm[0][0] = w*w + x*x - y*y - z*z;
      nm[0][1] = 2 * (x*y - w*z);
      nm[0][2] = 2 * (x*z + w*y);
      nm[1][0] = 2 * (x*y + w*z);
      nm[1][1] = w*w - x*x + y*y - z*z;
      nm[1][2] = 2 * (y*z - w*x);
      nm[2][0] = 2 * (x*z - w*y);
      nm[2][1] = 2 * (y*z + w*x);
      nm[2][2] = w*w - x*x - y*y + z*z;

      if (mode_reg[MODE_POS]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               mt[i][j] = round_by(nm[i][j], ROT_FRAC);
            end
         end
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
               acc += mt[i][j] * p[j];
            end
            v = round_by(acc, ROT_FRAC);
            sat |= out_of_range(v, POS_W);
            v = clamp_to(v, POS_W);
            v = round_by(v * sc[i], SCALE_FRAC) + tr[i];
            sat |= out_of_range(v, POS_W);
            op[i] = clamp_to(v, POS_W);
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            v = round_by(p[i] * sc[i], SCALE_FRAC);
            sat |= out_of_range(v, POS_W);
            op[i] = clamp_to(v, POS_W);
         end
      end

      if (mode_reg[MODE_ORI]) begin
         hm[0] = w*pq[0] + x*pq[3] + y*pq[2] - z*pq[1];
         hm[1] = w*pq[1] - x*pq[2] + y*pq[3] + z*pq[0];
         hm[2] = w*pq[2] + x*pq[1] - y*pq[0] + z*pq[3];
         hm[3] = w*pq[3] - x*pq[0] - y*pq[1] - z*pq[2];
         for (int i = 0; i < 4; i++) begin
            v = round_by(hm[i], ROT_FRAC);
            sat |= out_of_range(v, QUAT_W);
            oq[i] = clamp_to(v, QUAT_W);
         end
      end else begin
         // pass-through, never clamped
         for (int i = 0; i < 4; i++) begin
            oq[i] = pq[i];
         end
      end

      conf = longint'(conf_in) * longint'(gain_reg);
      conf = (conf + (longint'(1) <<< (CONF_FRAC - 1))) >>> CONF_FRAC;
      if (conf > longint'(CONF_MAX)) begin
         conf = longint'(CONF_MAX);
         sat = 1'b1;
      end

      for (int i = 0; i < 3; i++) begin
         res.pos[i] = POS_W'(op[i]);
      end
      for (int i = 0; i < 4; i++) begin
         res.quat[i] = QUAT_W'(oq[i]);
      end
      res.confidence = CONF_W'(conf);
      res.buttons    = buttons_in;
      res.saturated  = sat;
      return res;
   endfunction

   // one line per mismatch, log kept short on a badly broken design
   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%0t: result %0d, %s: got %h, expected %h",
                  $time, results_seen, field, got, want);
      end
   endtask

   task automatic compare_result(pose_result_t want);
      if (rsp_pos_x !== want.pos[0])        report_mismatch("pos_x", rsp_pos_x, want.pos[0]);
      if (rsp_pos_y !== want.pos[1])        report_mismatch("pos_y", rsp_pos_y, want.pos[1]);
      if (rsp_pos_z !== want.pos[2])        report_mismatch("pos_z", rsp_pos_z, want.pos[2]);
      if (rsp_quat_x !== want.quat[0])      report_mismatch("quat_x", rsp_quat_x, want.quat[0]);
      if (rsp_quat_y !== want.quat[1])      report_mismatch("quat_y", rsp_quat_y, want.quat[1]);
      if (rsp_quat_z !== want.quat[2])      report_mismatch("quat_z", rsp_quat_z, want.quat[2]);
      if (rsp_quat_w !== want.quat[3])      report_mismatch("quat_w", rsp_quat_w, want.quat[3]);
      if (rsp_confidence !== want.confidence) begin
         report_mismatch("confidence", rsp_confidence, want.confidence);
      end
      if (rsp_buttons !== want.buttons)     report_mismatch("buttons", rsp_buttons, want.buttons);
      if (rsp_saturated !== want.saturated) begin
         report_mismatch("saturated", rsp_saturated, want.saturated);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         trans_reg = '0;
         scale_reg = SCALE_RESET;
         rot_reg   = ROT_RESET;
         mode_reg  = '0;
         gain_reg  = GAIN_RESET;
         expected_poses.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_TRANS_X: trans_reg[0] = csr_wdata[POS_W-1:0];
               CSR_TRANS_Y: trans_reg[1] = csr_wdata[POS_W-1:0];
               CSR_TRANS_Z: trans_reg[2] = csr_wdata[POS_W-1:0];
               CSR_SCALE:   scale_reg    = csr_wdata[SCALE_PACK_W-1:0];
               CSR_ROT:     rot_reg      = csr_wdata[ROT_PACK_W-1:0];
               CSR_MODE:    mode_reg     = csr_wdata[1:0];
               CSR_GAIN:    gain_reg     = csr_wdata[CONF_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_poses.size() == 0) begin
               report_mismatch("result with no sample in flight", '0, '0);
            end else begin
               compare_result(expected_poses.pop_front());
            end
         end
         if (req_valid && !req_stall) begin
            expected_poses.push_back(transform_pose(
               {req_pos_z, req_pos_y, req_pos_x},
               {req_quat_w, req_quat_z, req_quat_y, req_quat_x},
               req_confidence, req_buttons));
         end
      end
      pending <= expected_poses.size();
   end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pose samples and register writes into the rigid pose transform,
// with random idling on both channels and long result-side hold-offs; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
   import prt_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int TIMEOUT_CYCLES  = 400000;
   localparam int RAND_PHASES     = 12;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int LONG_HOLD       = 200;

   localparam logic [POS_W-1:0]  POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0]  POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic [QUAT_W-1:0] Q_MAX   = {1'b0, {(QUAT_W-1){1'b1}}};
   localparam logic [QUAT_W-1:0] Q_MIN   = {1'b1, {(QUAT_W-1){1'b0}}};
   // index past the register list, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0][POS_W-1:0]  pos;
      logic [3:0][QUAT_W-1:0] quat;
      logic [CONF_W-1:0]      confidence;
      logic [BTN_W-1:0]       buttons;
   } pose_sample_t;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [POS_W-1:0]  req_pos_x, req_pos_y, req_pos_z;
   logic signed [QUAT_W-1:0] req_quat_x, req_quat_y, req_quat_z, req_quat_w;
   logic [CONF_W-1:0]        req_confidence;
   logic [BTN_W-1:0]         req_buttons;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [POS_W-1:0]  rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [QUAT_W-1:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic [CONF_W-1:0]        rsp_confidence;
   logic [BTN_W-1:0]         rsp_buttons;
   logic                     rsp_saturated;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   int                       fail_count;
   int                       pending;

   int sender_gap_pct     = 8;
   int receiver_stall_pct = 48;
   int hold_requests      = 0;

   pose_rigid_transform i_dut (.*);

   pose_transform_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Verification failed");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   function automatic logic [15:0] pick_extreme16();
      case ($urandom_range(5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'h0100;
         4: return 16'h4000;
         default: return 16'hC000;
      endcase
   endfunction

   function automatic logic [ROT_W-1:0] to_q14(real v);
      return ROT_W'($rtoi(v * 16384.0 + ((v < 0.0) ? -0.5 : 0.5)));
   endfunction

   function automatic pose_sample_t random_pose();
      pose_sample_t s;
      logic [31:0]  r;
      for (int i = 0; i < 3; i++) begin
         r = $urandom;
         case ($urandom_range(7))
            0:       s.pos[i] = $urandom_range(1) ? POS_MAX : POS_MIN;
            1, 2, 3: s.pos[i] = {{8{r[23]}}, r[23:0]};
            default: s.pos[i] = r;
         endcase
      end
      for (int i = 0; i < 4; i++) begin
         r = $urandom;
         case ($urandom_range(3))
            0:       s.quat[i] = pick_extreme16();
            1:       s.quat[i] = {{2{r[14]}}, r[13:0]};
            default: s.quat[i] = r[QUAT_W-1:0];
         endcase
      end
      // now and then a confidence above one
      s.confidence = ($urandom_range(15) == 0) ? CONF_W'($urandom)
                                               : CONF_W'($urandom_range(32768));
      s.buttons = $urandom;
      return s;
   endfunction

   function automatic pose_sample_t directed_pose(int k);
      pose_sample_t s;
      case (k)
         0: s = '0;
         1: s = {{POS_MAX, POS_MAX, POS_MAX}, {Q_MAX, Q_MAX, Q_MAX, Q_MAX},
                 CONF_MAX, 16'hFFFF};
         2: s = {{POS_MIN, POS_MIN, POS_MIN}, {Q_MIN, Q_MIN, Q_MIN, Q_MIN},
                 CONF_MAX, 16'h0000};
         3: s = {{32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0001},
                 {16'h0001, 16'h0000, 16'hC000, 16'h4000}, 16'hFFFF, 16'hA5A5};
         default: s = {{32'h1234_5678, 32'hFFFF_0000, 32'h0001_0000},
                       {16'h2D41, 16'h0000, 16'hD2BF, 16'h0000}, 16'h4000, 16'h5A5A};
      endcase
      return s;
   endfunction

   task automatic offer_pose(pose_sample_t s);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pos_x      <= s.pos[0];
      req_pos_y      <= s.pos[1];
      req_pos_z      <= s.pos[2];
      req_quat_x     <= s.quat[0];
      req_quat_y     <= s.quat[1];
      req_quat_z     <= s.quat[2];
      req_quat_w     <= s.quat[3];
      req_confidence <= s.confidence;
      req_buttons    <= s.buttons;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending until every result is back, then let the pipe settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2 * NUM_STAGES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_random_settings(int phase);
      logic [CSR_DATA_W-1:0]   junk;
      logic [POS_W-1:0]        trans;
      logic [SCALE_PACK_W-1:0] scale;
      logic [ROT_PACK_W-1:0]   rot;
      logic [CONF_W-1:0]       gain;
      logic [1:0]              mode;
      real ax, ay, az, len, half, sn;
      bit extreme;
      extreme = (phase % 4 == 3);

      for (int i = 0; i < 3; i++) begin
         junk  = {$urandom, $urandom};
         trans = $urandom;
         if (extreme) begin
            trans = $urandom_range(1) ? POS_MAX : POS_MIN;
         end else if ($urandom_range(1)) begin
            trans = {{12{trans[19]}}, trans[19:0]};
         end
         write_register(CSR_IDX_W'(CSR_TRANS_X + i), {junk[63:32], trans});
      end

      for (int i = 0; i < 3; i++) begin
         if (extreme) begin
            scale[SCALE_W*i +: SCALE_W] = pick_extreme16();
         end else if ($urandom_range(1)) begin
            scale[SCALE_W*i +: SCALE_W] = 16'h0100 + 16'($urandom_range(511)) - 16'd256;
         end else begin
            scale[SCALE_W*i +: SCALE_W] = $urandom;
         end
      end
      junk = {$urandom, $urandom};
      write_register(CSR_SCALE, {junk[63:48], scale});

      if (extreme) begin
         for (int i = 0; i < 4; i++) begin
            rot[ROT_W*i +: ROT_W] = pick_extreme16();
         end
      end else begin
         case ($urandom_range(4))
            0, 1, 2: begin
               // near-unit rotation about a random axis
               ax = $itor($urandom_range(2000)) - 1000.0;
               ay = $itor($urandom_range(2000)) - 1000.0;
               az = $itor($urandom_range(2000)) - 1000.0;
               len = $sqrt(ax*ax + ay*ay + az*az);
               if (len < 1.0) begin
                  ax = 1.0;
                  len = 1.0;
               end
               half = $itor($urandom_range(3141)) / 1000.0;
               sn = $sin(half);
               rot = {to_q14($cos(half)), to_q14(sn * az / len),
                      to_q14(sn * ay / len), to_q14(sn * ax / len)};
            end
            3: rot = {$urandom, $urandom};
            default: begin
               rot = '0;
               rot[ROT_W*$urandom_range(3) +: ROT_W] = $urandom_range(1) ? 16'h4000
                                                                         : 16'hC000;
            end
         endcase
      end
      write_register(CSR_ROT, rot);

      mode = 2'((phase + phase / 4) % 4);
      junk = {$urandom, $urandom};
      write_register(CSR_MODE, {junk[63:2], mode});

      if (extreme) begin
         case ($urandom_range(2))
            0:       gain = '0;
            1:       gain = CONF_MAX;
            default: gain = '1;
         endcase
      end else begin
         case ($urandom_range(19))
            0, 1, 2: gain = CONF_MAX;
            3, 4, 5: gain = $urandom;
            default: gain = CONF_W'($urandom_range(32768));
         endcase
      end
      junk = {$urandom, $urandom};
      write_register(CSR_GAIN, {junk[63:16], gain});
   endtask

   initial begin
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_pos_x      <= '0;
      req_pos_y      <= '0;
      req_pos_z      <= '0;
      req_quat_x     <= '0;
      req_quat_y     <= '0;
      req_quat_z     <= '0;
      req_quat_w     <= '0;
      req_confidence <= '0;
      req_buttons    <= '0;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, then three hand-picked settings
      for (int d = 0; d < 4; d++) begin
         case (d)
            1: begin
               // 90 degrees about z, both modes on
               write_register(CSR_TRANS_X, {$urandom, POS_MAX});
               write_register(CSR_TRANS_Y, {$urandom, POS_MIN});
               write_register(CSR_TRANS_Z, {32'd0, 32'h0001_0000});
               write_register(CSR_SCALE, {16'hFFFF, 16'h0100, 16'h8000, 16'h7FFF});
               write_register(CSR_ROT, {16'h2D41, 16'h2D41, 16'h0000, 16'h0000});
               write_register(CSR_MODE, {62'd0, 2'b11});
               write_register(CSR_GAIN, {$urandom, 16'hFFFF, 16'h4000});
            end
            2: begin
               // oversized rotation, orientation passed through
               write_register(CSR_TRANS_X, {32'd0, POS_MIN});
               write_register(CSR_TRANS_Y, {32'd0, POS_MIN});
               write_register(CSR_TRANS_Z, {32'd0, POS_MIN});
               write_register(CSR_SCALE, {16'h0000, {3{16'h8000}}});
               write_register(CSR_ROT, {4{16'h8000}});
               write_register(CSR_MODE, CSR_DATA_W'(1 << MODE_POS));
               write_register(CSR_GAIN, {48'd0, 16'hFFFF});
            end
            3: begin
               write_register(CSR_TRANS_X, '0);
               write_register(CSR_TRANS_Y, '0);
               write_register(CSR_TRANS_Z, '0);
               write_register(CSR_SCALE, '0);
               write_register(CSR_ROT, {4{16'h7FFF}});
               write_register(CSR_MODE, CSR_DATA_W'(1 << MODE_ORI));
               write_register(CSR_GAIN, '0);
               write_register(CSR_UNUSED, '1);
            end
            default: ;
         endcase
         for (int k = 0; k < 5; k++) begin
            offer_pose(directed_pose(k));
         end
         wait_drained();
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         sender_gap_pct     = (p < 4) ? 8 : (p < 8) ? 48 : 0;
         receiver_stall_pct = (p < 4) ? 48 : (p < 8) ? 8 : 0;
         load_random_settings(p);
         if (p == 1 || p == 9) begin
            hold_requests++;
         end
         repeat (ITEMS_PER_PHASE) offer_pose(random_pose());
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/prt_pkg.sv
src/prt_csr.sv
src/prt_ctrl.sv
src/prt_position.sv
src/prt_orient.sv
src/pose_rigid_transform.sv
tb/pose_transform_checker.sv
tb/testbench.sv
